// ===== rtl/spws_pkg.sv =====
// ----------------------------------------------------------------------------
// spws_pkg
// Types, codes and constant tables shared by the square-path steering block.
// ----------------------------------------------------------------------------
package spws_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_TABLE_LEN   = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int CORNER_COUNT     = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [1:0] MODE_ARRIVE = 2'd0;
    localparam logic [1:0] MODE_TURN   = 2'd1;
    localparam logic [1:0] MODE_DRIVE  = 2'd2;
    localparam logic [1:0] MODE_DONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAP_TARGET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_TOLERANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED        = 3'd5;

    typedef struct packed {
        logic               action;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] linear_cmd;
        logic [15:0] angular_cmd;
        logic [1:0]  corner_number;
        logic [15:0] laps_done;
    } t_out_item;

    typedef struct packed {
        logic [14:0] side_length;
        logic [15:0] lap_target;
        logic [15:0] arrive_radius;
        logic [14:0] heading_tolerance;
        logic [15:0] drive_speed;
        logic [15:0] turn_speed;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic diff;
        logic sq_x;
        logic sq_y;
        logic sq_r;
        logic cinit;
        logic cstep;
        logic res_restart;
        logic res_done;
        logic res_arrive;
        logic res_steer;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic done;
        logic arrived;
        logic last_step;
    } t_sts;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // unit corners: (1,0) (1,1) (0,1) (0,0)
    function automatic logic corner_ux(input logic [1:0] c);
        return (c == 2'd0) || (c == 2'd1);
    endfunction

    function automatic logic corner_uy(input logic [1:0] c);
        return (c == 2'd1) || (c == 2'd2);
    endfunction

endpackage

// ===== rtl/spws_cfg.sv =====
// ----------------------------------------------------------------------------
// spws_cfg
// Configuration register file with write decoder and reset defaults.
// ----------------------------------------------------------------------------
module spws_cfg
    import spws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIDE_LENGTH:       n_cfg.side_length       = i_cfg_data[14:0];
                CFG_LAP_TARGET:        n_cfg.lap_target        = i_cfg_data;
                CFG_ARRIVE_RADIUS:     n_cfg.arrive_radius     = i_cfg_data;
                CFG_HEADING_TOLERANCE: n_cfg.heading_tolerance = i_cfg_data[14:0];
                CFG_DRIVE_SPEED:       n_cfg.drive_speed       = i_cfg_data;
                CFG_TURN_SPEED:        n_cfg.turn_speed        = i_cfg_data;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.side_length       <= 15'd1;
            r_cfg.lap_target        <= 16'd1;
            r_cfg.arrive_radius     <= 16'd655;
            r_cfg.heading_tolerance <= 15'd910;
            r_cfg.drive_speed       <= 16'd51;
            r_cfg.turn_speed        <= 16'd51;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/spws_dp.sv =====
// ----------------------------------------------------------------------------
// spws_dp
// Datapath: corner offset, squared-distance test on a shared multiplier,
// iterative CORDIC atan2, heading decision and run state.
// ----------------------------------------------------------------------------
module spws_dp
    import spws_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_res
);

    localparam int ITERS  = (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STEPS;
    localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam logic [ITER_W-1:0] LAST_ITER   = ITER_W'(ITERS - 1);
    localparam logic [1:0]        LAST_CORNER = 2'(CORNER_COUNT - 1);
    localparam logic signed [33:0] NEAR_LIM   = 34'sd65536;

    t_in_item           r_item;
    logic [1:0]         r_corner;
    logic [15:0]        r_lap;
    logic [15:0]        r_held_lin;
    logic [15:0]        r_held_ang;
    logic signed [33:0] r_dx;
    logic signed [33:0] r_dy;
    logic               r_near;
    logic               r_zero;
    logic [32:0]        r_d2;
    logic [31:0]        r_r2;
    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic [31:0]        r_acc;
    logic [ITER_W-1:0]  r_iter;
    t_out_item          r_res;

    // corner offset
    logic [30:0]        w_tx;
    logic [30:0]        w_ty;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;

    assign w_tx = corner_ux(r_corner) ? {i_cfg.side_length, 16'h0000} : 31'd0;
    assign w_ty = corner_uy(r_corner) ? {i_cfg.side_length, 16'h0000} : 31'd0;
    assign w_dx = $signed({3'b000, w_tx}) - $signed({{2{r_item.pos_x[31]}}, r_item.pos_x});
    assign w_dy = $signed({3'b000, w_ty}) - $signed({{2{r_item.pos_y[31]}}, r_item.pos_y});

    // shared squarer
    logic [33:0] w_abs_dx;
    logic [33:0] w_abs_dy;
    logic [15:0] w_mul_a;
    logic [31:0] w_prod;

    assign w_abs_dx = r_dx[33] ? 34'(-r_dx) : 34'(r_dx);
    assign w_abs_dy = r_dy[33] ? 34'(-r_dy) : 34'(r_dy);

    always_comb begin
        if (i_cmd.sq_x) begin
            w_mul_a = w_abs_dx[15:0];
        end else if (i_cmd.sq_y) begin
            w_mul_a = w_abs_dy[15:0];
        end else begin
            w_mul_a = i_cfg.arrive_radius;
        end
    end

    assign w_prod = 32'(w_mul_a) * 32'(w_mul_a);

    // CORDIC
    logic signed [35:0] w_x0;
    logic signed [35:0] w_y0;
    logic signed [35:0] w_xs;
    logic signed [35:0] w_ys;
    logic [31:0]        w_atan;

    assign w_x0   = {{2{r_dx[33]}}, r_dx};
    assign w_y0   = {{2{r_dy[33]}}, r_dy};
    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = atan_entry(ATAN_IDX_W'(r_iter));

    // heading decision
    logic [31:0] w_round;
    logic [15:0] w_target;
    logic [15:0] w_err;
    logic [16:0] w_mag;
    logic        w_drive;

    assign w_round  = r_acc + 32'h0000_8000;
    assign w_target = r_zero ? 16'h0000 : w_round[31:16];
    assign w_err    = w_target - r_item.heading;
    assign w_mag    = w_err[15] ? (17'h10000 - {1'b0, w_err}) : {1'b0, w_err};
    assign w_drive  = w_mag < {2'b00, i_cfg.heading_tolerance};

    // arrival update
    logic [1:0]  w_corner_next;
    logic [15:0] w_lap_next;

    assign w_corner_next = r_corner + 2'd1;
    assign w_lap_next    = ((r_corner == LAST_CORNER) && (r_lap != 16'hFFFF))
                         ? r_lap + 16'd1 : r_lap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner   <= 2'd0;
            r_lap      <= 16'd0;
            r_held_lin <= 16'd0;
            r_held_ang <= 16'd0;
        end else begin
            if (i_cmd.res_restart) begin
                r_corner <= 2'd0;
                r_lap    <= 16'd0;
            end
            if (i_cmd.res_arrive) begin
                r_corner <= w_corner_next;
                r_lap    <= w_lap_next;
            end
            if (i_cmd.res_steer) begin
                r_held_lin <= w_drive ? i_cfg.drive_speed : 16'd0;
                r_held_ang <= w_drive ? 16'd0 : i_cfg.turn_speed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.diff) begin
            r_dx   <= w_dx;
            r_dy   <= w_dy;
            r_near <= (w_dx < NEAR_LIM) && (w_dx > -NEAR_LIM)
                   && (w_dy < NEAR_LIM) && (w_dy > -NEAR_LIM);
            r_zero <= (w_dx == 34'sd0) && (w_dy == 34'sd0);
        end
        if (i_cmd.sq_x) begin
            r_d2 <= {1'b0, w_prod};
        end
        if (i_cmd.sq_y) begin
            r_d2 <= r_d2 + {1'b0, w_prod};
        end
        if (i_cmd.sq_r) begin
            r_r2 <= w_prod;
        end
        if (i_cmd.cinit) begin
            r_iter <= '0;
            if (w_x0 < 0) begin
                if (w_y0 >= 0) begin
                    r_x   <= w_y0;
                    r_y   <= -w_x0;
                    r_acc <= 32'h4000_0000;
                end else begin
                    r_x   <= -w_y0;
                    r_y   <= w_x0;
                    r_acc <= 32'hC000_0000;
                end
            end else begin
                r_x   <= w_x0;
                r_y   <= w_y0;
                r_acc <= 32'h0000_0000;
            end
        end
        if (i_cmd.cstep) begin
            r_iter <= r_iter + ITER_W'(1);
            if (!r_y[35]) begin
                r_x   <= r_x + w_ys;
                r_y   <= r_y - w_xs;
                r_acc <= r_acc + w_atan;
            end else begin
                r_x   <= r_x - w_ys;
                r_y   <= r_y + w_xs;
                r_acc <= r_acc - w_atan;
            end
        end
        if (i_cmd.res_restart) begin
            r_res <= '{mode: MODE_ARRIVE, linear_cmd: r_held_lin, angular_cmd: r_held_ang,
                       corner_number: 2'd0, laps_done: 16'd0};
        end
        if (i_cmd.res_done) begin
            r_res <= '{mode: MODE_DONE, linear_cmd: 16'd0, angular_cmd: 16'd0,
                       corner_number: r_corner, laps_done: r_lap};
        end
        if (i_cmd.res_arrive) begin
            r_res <= '{mode: MODE_ARRIVE, linear_cmd: r_held_lin, angular_cmd: r_held_ang,
                       corner_number: w_corner_next, laps_done: w_lap_next};
        end
        if (i_cmd.res_steer) begin
            r_res <= '{mode: w_drive ? MODE_DRIVE : MODE_TURN,
                       linear_cmd: w_drive ? i_cfg.drive_speed : 16'd0,
                       angular_cmd: w_drive ? 16'd0 : i_cfg.turn_speed,
                       corner_number: r_corner, laps_done: r_lap};
        end
    end

    assign o_sts.restart   = r_item.action;
    assign o_sts.done      = r_lap >= i_cfg.lap_target;
    assign o_sts.arrived   = r_near && (r_d2 < {1'b0, r_r2});
    assign o_sts.last_step = (r_iter == LAST_ITER);
    assign o_res           = r_res;

    a_arrive_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_arrive |=> r_corner == $past(r_corner) + 2'd1)
        else $error("corner did not advance on arrival");

    a_one_command_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_steer |=> (r_held_lin == 16'd0) || (r_held_ang == 16'd0))
        else $error("drive and turn commanded together");

    a_laps_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.res_restart |=> r_lap >= $past(r_lap))
        else $error("lap count dropped without restart");

endmodule

// ===== rtl/spws_ctrl.sv =====
// ----------------------------------------------------------------------------
// spws_ctrl
// Sequencer: accepts a request, steps the datapath through the distance
// test and the CORDIC, and owns the result valid flag.
// ----------------------------------------------------------------------------
module spws_ctrl
    import spws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SQX,
        S_SQY,
        S_SQR,
        S_JUDGE,
        S_CSTEP,
        S_STEER
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;
    logic   w_res_any;
    t_cmd   w_cmd;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                w_cmd.diff = 1'b1;
                if (i_sts.restart || i_sts.done) begin
                    if (w_slot_free) begin
                        w_cmd.res_restart = i_sts.restart;
                        w_cmd.res_done    = !i_sts.restart;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                w_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                w_cmd.sq_y = 1'b1;
                n_state    = S_SQR;
            end
            S_SQR: begin
                w_cmd.sq_r = 1'b1;
                n_state    = S_JUDGE;
            end
            S_JUDGE: begin
                if (i_sts.arrived) begin
                    if (w_slot_free) begin
                        w_cmd.res_arrive = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    w_cmd.cinit = 1'b1;
                    n_state     = S_CSTEP;
                end
            end
            S_CSTEP: begin
                w_cmd.cstep = 1'b1;
                if (i_sts.last_step) begin
                    n_state = S_STEER;
                end
            end
            S_STEER: begin
                if (w_slot_free) begin
                    w_cmd.res_steer = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_res_any = w_cmd.res_restart || w_cmd.res_done
                    || w_cmd.res_arrive || w_cmd.res_steer;

    always_comb begin
        if (w_res_any) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_any |=> o_out_valid)
        else $error("result written without valid");

    a_cordic_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CSTEP && !i_sts.last_step) |=> r_state == S_CSTEP)
        else $error("CORDIC left early");

endmodule

// ===== rtl/square_path_waypoint_steering.sv =====
// ----------------------------------------------------------------------------
// square_path_waypoint_steering
// Steers a robot around the corners of a square for a set number of laps.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_item): one request per pose
// tick or restart. Output channel (o_out_valid / i_out_ready / o_out_item):
// exactly one result per request, in order. Config channel (i_cfg_valid /
// o_cfg_ready / i_cfg_index / i_cfg_data) is always ready; write only idle.
// One request is worked at a time. A restart or done result is written from
// the DECIDE state; a reached corner from JUDGE, after the distance test in
// SQX, SQY and SQR; a steering result from STEER, after the CORDIC steps.
// The CORDIC iteration loop, one rotation per cycle, sets the steering time.
// The distance test shares one 16x16 squarer across those states.
// A finished result sits in the output register while the next request is
// taken; if the receiver stalls, the block finishes its current request and
// waits before writing the result. Reset (synchronous, active low) clears
// corner and lap counters and held commands and loads register defaults.
// ----------------------------------------------------------------------------
module square_path_waypoint_steering
    import spws_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    spws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    spws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    spws_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cfg   (w_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_out_item)
    );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the square-path waypoint steering block.
// ----------------------------------------------------------------------------
// Pose and restart requests go out through a bursty driver fed from a queue.
// A stalling monitor takes the results. Each accepted request is run through
// a local steering model: corner targets, arrival radius, CORDIC bearing and
// wrapped heading error. That gives one expected command per request, and the
// monitor compares it field by field. A short directed part comes first:
// heading tolerance edges, extreme poses, the arrival boundary, a full lap,
// done, restart, the far-away rule and the zero-vector bearing. It is followed
// by phases of random poses, each under its own register setting. Most poses
// follow the square, so laps complete and the done state is reached.
// ----------------------------------------------------------------------------
module tb;
    import spws_pkg::*;

    localparam logic ACT_POSE    = 1'b0;
    localparam logic ACT_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int  NSTEPS = (CORDIC_STEPS_DEF > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN
                                                                  : CORDIC_STEPS_DEF;
    localparam longint METER          = 65536;
    localparam int     REQS_PER_PHASE = 80;
    localparam int     RANDOM_PHASES  = 10;
    localparam int     DRAIN_CYCLES   = 40;
    localparam int     RUN_LIMIT      = 5000000;

    typedef struct packed {
        logic [1:0]  corner;
        logic [15:0] laps;
        logic [15:0] lin;
        logic [15:0] ang;
    } t_nav;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    t_in_item              in_item     = '0;
    logic                  out_ready   = 1'b1;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_item;
    logic                  cfg_ready;

    t_cfg cfg = '{side_length: 15'd1, lap_target: 16'd1, arrive_radius: 16'd655,
                  heading_tolerance: 15'd910, drive_speed: 16'd51, turn_speed: 16'd51};
    t_nav nav  = '0;
    t_nav plan = '0;

    t_in_item  req_queue[$];
    t_out_item expected_cmds[$];
    t_out_item want_cmd;
    t_out_item accepted_cmd;

    int fail_count  = 0;
    int n_accepted  = 0;
    int n_checked   = 0;
    int n_settings  = 0;
    int mode_seen[4] = '{0, 0, 0, 0};
    bit no_idle     = 1'b1;
    int burst_left  = 0;
    int gap_left    = 0;
    int stall_left  = 0;

    square_path_waypoint_steering dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // steering model
    // ------------------------------------------------------------------
    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // atan2(y, x), 65536 per turn
    function automatic logic [15:0] heading_of(input longint x0, input longint y0);
        longint      x;
        longint      y;
        longint      t;
        longint      xs;
        longint      ys;
        logic [31:0] acc;
        logic [31:0] rounded;
        x   = x0;
        y   = y0;
        acc = 32'd0;
        if (x == 0 && y == 0) begin
            return 16'd0;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                acc = 32'h4000_0000;
            end else begin
                t = x; x = -y; y = t;
                acc = 32'hC000_0000;
            end
        end
        for (int i = 0; i < NSTEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + atan_step(i);
            end else begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - atan_step(i);
            end
        end
        rounded = acc + 32'h0000_8000;
        return rounded[31:16];
    endfunction

    function automatic longint corner_tx(input logic [1:0] c, input t_cfg k);
        return (~c[1]) ? longint'(k.side_length) * METER : 64'sd0;
    endfunction

    function automatic longint corner_ty(input logic [1:0] c, input t_cfg k);
        return (c[0] ^ c[1]) ? longint'(k.side_length) * METER : 64'sd0;
    endfunction

    function automatic t_out_item steer_predict(inout t_nav st, input t_cfg k,
                                                input t_in_item it);
        t_out_item   r;
        longint      dx;
        longint      dy;
        longint      rad;
        logic        hit;
        logic [15:0] err;
        logic [16:0] mag;
        r = '0;
        if (it.action == ACT_RESTART) begin
            st.corner = 2'd0;
            st.laps   = 16'd0;
            r.mode        = MODE_ARRIVE;
            r.linear_cmd  = st.lin;
            r.angular_cmd = st.ang;
        end else if (st.laps >= k.lap_target) begin
            r.mode        = MODE_DONE;
            r.linear_cmd  = 16'd0;
            r.angular_cmd = 16'd0;
        end else begin
            dx  = corner_tx(st.corner, k) - longint'($signed(it.pos_x));
            dy  = corner_ty(st.corner, k) - longint'($signed(it.pos_y));
            rad = longint'(k.arrive_radius);
            if (dx >= METER || dx <= -METER || dy >= METER || dy <= -METER) begin
                hit = 1'b0;
            end else begin
                hit = (dx * dx + dy * dy) < (rad * rad);
            end
            if (hit) begin
                st.corner = st.corner + 2'd1;
                if (st.corner == 2'd0 && st.laps != 16'hFFFF) begin
                    st.laps = st.laps + 16'd1;
                end
                r.mode        = MODE_ARRIVE;
            end else begin
                err = heading_of(dx, dy) - it.heading;
                mag = err[15] ? (17'h10000 - {1'b0, err}) : {1'b0, err};
                if (mag < {2'b00, k.heading_tolerance}) begin
                    st.lin = k.drive_speed;
                    st.ang = 16'd0;
                    r.mode = MODE_DRIVE;
                end else begin
                    st.lin = 16'd0;
                    st.ang = k.turn_speed;
                    r.mode = MODE_TURN;
                end
            end
            r.linear_cmd  = st.lin;
            r.angular_cmd = st.ang;
        end
        r.corner_number = st.corner;
        r.laps_done     = st.laps;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // register writes
    // ------------------------------------------------------------------
    function automatic void shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_SIDE_LENGTH:       cfg.side_length       = d[14:0];
            CFG_LAP_TARGET:        cfg.lap_target        = d;
            CFG_ARRIVE_RADIUS:     cfg.arrive_radius     = d;
            CFG_HEADING_TOLERANCE: cfg.heading_tolerance = d[14:0];
            CFG_DRIVE_SPEED:       cfg.drive_speed       = d;
            CFG_TURN_SPEED:        cfg.turn_speed        = d;
            default: ;
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_write(idx, d);
    endtask

    task automatic set_regs(input logic [15:0] side, input logic [15:0] laps,
                            input logic [15:0] rad, input logic [15:0] tol,
                            input logic [15:0] drv, input logic [15:0] trn);
        cfg_write(CFG_SIDE_LENGTH, side);
        cfg_write(CFG_LAP_TARGET, laps);
        cfg_write(CFG_ARRIVE_RADIUS, rad);
        cfg_write(CFG_HEADING_TOLERANCE, tol);
        cfg_write(CFG_DRIVE_SPEED, drv);
        cfg_write(CFG_TURN_SPEED, trn);
        n_settings++;
    endtask

    task automatic wait_idle();
        while (in_valid || req_queue.size() != 0 || expected_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // request generation
    // ------------------------------------------------------------------
    function automatic void push_pose(input logic signed [31:0] x, input logic signed [31:0] y,
                                      input logic [15:0] h);
        t_in_item it;
        it.action  = ACT_POSE;
        it.pos_x   = x;
        it.pos_y   = y;
        it.heading = h;
        req_queue.push_back(it);
    endfunction

    function automatic void push_restart();
        t_in_item it;
        it         = '0;
        it.action  = ACT_RESTART;
        it.pos_x   = $urandom;
        it.pos_y   = $urandom;
        it.heading = 16'($urandom);
        req_queue.push_back(it);
    endfunction

    // mostly poses that follow the square from the planned corner
    task automatic gen_random_req();
        t_in_item    it;
        t_out_item   discard;
        longint      tx;
        longint      ty;
        longint      dx;
        longint      dy;
        longint      lim;
        longint      rad;
        longint      t;
        int unsigned pick;
        logic [15:0] tol;
        logic [15:0] delta;
        rad  = longint'(cfg.arrive_radius);
        tol  = {1'b0, cfg.heading_tolerance};
        tx   = corner_tx(plan.corner, cfg);
        ty   = corner_ty(plan.corner, cfg);
        dx   = 0;
        dy   = 0;
        it.action  = ACT_POSE;
        it.heading = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            it.action = ACT_RESTART;
            dx = longint'($signed($urandom)) >>> $urandom_range(0, 31);
            dy = longint'($signed($urandom)) >>> $urandom_range(0, 31);
        end else if (pick < 35) begin
            lim = (rad * 7) / 10;
            dx  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
            dy  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        end else if (pick < 38) begin
            dx = 0;
            dy = 0;
        end else if (pick < 44) begin
            dx = ($urandom_range(0, 1) == 0 || rad == 0) ? rad : rad - 1;
            if ($urandom_range(0, 1) == 1) dx = -dx;
            if ($urandom_range(0, 1) == 1) begin
                t = dx; dx = dy; dy = t;
            end
        end else if (pick < 47) begin
            dx = ($urandom_range(0, 1) == 0) ? METER : -METER;
            dy = longint'($urandom_range(0, 32'(2 * rad))) - rad;
            if ($urandom_range(0, 1) == 1) begin
                t = dx; dx = dy; dy = t;
            end
        end else if (pick < 90) begin
            dx = longint'($signed($urandom)) >>> $urandom_range(6, 31);
            dy = longint'($signed($urandom)) >>> $urandom_range(6, 31);
        end
        it.pos_x = 32'(tx - dx);
        it.pos_y = 32'(ty - dy);
        if (pick >= 90) begin
            it.pos_x = $urandom;
            it.pos_y = $urandom;
        end
        if (pick >= 47 && pick < 90 && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 5))
                0: delta = tol;
                1: delta = tol - 16'd1;
                2: delta = -tol;
                3: delta = 16'd1 - tol;
                4: delta = 16'd0;
                default: delta = 16'h8000;
            endcase
            it.heading = heading_of(tx - longint'($signed(it.pos_x)),
                                    ty - longint'($signed(it.pos_y))) - delta;
        end
        req_queue.push_back(it);
        discard = steer_predict(plan, cfg, it);
    endtask

    function automatic logic [15:0] pick_radius();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(100, 20000));
    endfunction

    task automatic program_phase(input int ph);
        case (ph)
            0: set_regs(16'd1, 16'd2, 16'd13100, 16'd910, 16'($urandom), 16'($urandom));
            1: begin
                set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                cfg_write(CFG_SPARE_LO, 16'($urandom));
                cfg_write(CFG_SPARE_HI, 16'($urandom));
            end
            2: set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            3: set_regs(16'h8000, 16'd3, pick_radius(), 16'($urandom),
                        16'($urandom), 16'($urandom));
            4: set_regs(16'($urandom_range(1, 3)), 16'd4, pick_radius(),
                        16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom));
            5: set_regs(16'($urandom_range(0, 3)), 16'd1, pick_radius(),
                        16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom));
            default: set_regs(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 4)),
                              16'($urandom_range(0, 4)), pick_radius(),
                              16'($urandom), 16'($urandom), 16'($urandom));
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver: bursts with gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                accepted_cmd = steer_predict(nav, cfg, in_item);
                expected_cmds.push_back(accepted_cmd);
                n_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (req_queue.size() != 0) begin
                    in_item  <= req_queue.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        if (no_idle) begin
                            gap_left = 0;
                        end else if ($urandom_range(0, 3) == 0) begin
                            gap_left = $urandom_range(20, 60);
                        end else begin
                            gap_left = $urandom_range(0, 6);
                        end
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stalls and result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 30);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_cmds.size() == 0) begin
                $error("result with no pending request: mode %0d", out_item.mode);
                fail_count++;
            end else begin
                want_cmd = expected_cmds.pop_front();
                check_field("mode", want_cmd.mode, out_item.mode);
                check_field("linear_cmd", want_cmd.linear_cmd, out_item.linear_cmd);
                check_field("angular_cmd", want_cmd.angular_cmd, out_item.angular_cmd);
                check_field("corner_number", want_cmd.corner_number, out_item.corner_number);
                check_field("laps_done", want_cmd.laps_done, out_item.laps_done);
                mode_seen[out_item.mode]++;
                n_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: tolerance edges, extreme poses, one full lap
        n_settings++;
        push_restart();
        push_pose(32'sd0, 32'sd0, 16'h0000);
        push_pose(32'sd0, 32'sd0, 16'h8000);
        push_pose(32'sd0, 32'sd0, 16'd910);
        push_pose(32'sd0, 32'sd0, 16'd909);
        push_pose(32'sd0, 32'sd0, 16'hFC73);
        push_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        push_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
        push_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h1234);
        push_pose(32'(METER - 655), 32'sd0, 16'h0000);
        push_pose(32'(METER - 654), 32'sd0, 16'h0000);
        push_pose(32'(METER), 32'(METER), 16'h4000);
        push_pose(32'(METER / 2), 32'(METER), 16'hC000);
        push_pose(32'sd300, 32'(METER - 300), 16'h0000);
        push_pose(-32'sd400, 32'sd200, 16'h0000);
        push_pose(32'sd0, 32'sd0, 16'h0000);
        push_restart();
        push_pose(32'(METER), -32'(METER), 16'h0000);
        wait_idle();

        // widest radius: far-away rule and the equal-distance edge
        set_regs(16'd1, 16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        push_restart();
        push_pose(32'sd0, 32'sd0, 16'h0000);
        push_pose(32'sd1, 32'sd0, 16'h0000);
        push_pose(32'sd2, 32'sd0, 16'h0000);
        wait_idle();

        // zero radius: exactly on the corner gives bearing zero
        set_regs(16'd1, 16'd1, 16'd0, 16'd1, 16'd100, 16'd200);
        push_restart();
        push_pose(32'(METER), 32'sd0, 16'h0000);
        push_pose(32'(METER), 32'sd0, 16'h0001);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            program_phase(ph);
            plan    = nav;
            no_idle = (ph % 3 == 1);
            repeat (REQS_PER_PHASE) gen_random_req();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results from %0d requests over %0d register settings",
                 n_checked, n_accepted, n_settings);
        $display("Modes seen: arrive %0d, turn %0d, drive %0d, done %0d",
                 mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        if (fail_count == 0 && expected_cmds.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spws_pkg.sv
rtl/spws_cfg.sv
rtl/spws_dp.sv
rtl/spws_ctrl.sv
rtl/square_path_waypoint_steering.sv
dv/tb.sv
